// ===== hw/rtl/clx_pkg.sv =====
// Package with the token codes, lexer modes and queue record types of the C token lexer.
`timescale 1ns / 1ps
`default_nettype none

package clx_pkg;

    // Token kind codes.
    localparam logic [4:0] K_UNKNOWN = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_STRING  = 5'd2;
    localparam logic [4:0] K_CHAR    = 5'd3;
    localparam logic [4:0] K_DIVIDE  = 5'd4;
    localparam logic [4:0] K_LINE    = 5'd5;
    localparam logic [4:0] K_BLOCK   = 5'd6;
    localparam logic [4:0] K_HASH    = 5'd7;
    localparam logic [4:0] K_LPAREN  = 5'd8;
    localparam logic [4:0] K_RPAREN  = 5'd9;
    localparam logic [4:0] K_LBRACE  = 5'd10;
    localparam logic [4:0] K_RBRACE  = 5'd11;
    localparam logic [4:0] K_LBRACK  = 5'd12;
    localparam logic [4:0] K_RBRACK  = 5'd13;
    localparam logic [4:0] K_SEMI    = 5'd14;
    localparam logic [4:0] K_COLON   = 5'd15;
    localparam logic [4:0] K_QUEST   = 5'd16;
    localparam logic [4:0] K_COMMA   = 5'd17;
    localparam logic [4:0] K_PERCENT = 5'd18;
    localparam logic [4:0] K_ASSIGN  = 5'd19;
    localparam logic [4:0] K_STAR    = 5'd20;
    localparam logic [4:0] K_LESS    = 5'd21;
    localparam logic [4:0] K_GREATER = 5'd22;
    localparam logic [4:0] K_CARET   = 5'd23;
    localparam logic [4:0] K_END     = 5'd24;

    // Source bytes with a special role.
    localparam logic [7:0] B_END     = 8'h00;
    localparam logic [7:0] B_NEWLINE = 8'h0A;
    localparam logic [7:0] B_DQUOTE  = 8'h22;
    localparam logic [7:0] B_HASH    = 8'h23;
    localparam logic [7:0] B_SQUOTE  = 8'h27;
    localparam logic [7:0] B_STAR    = 8'h2A;
    localparam logic [7:0] B_SLASH   = 8'h2F;
    localparam logic [7:0] B_CARET   = 8'h5E;
    localparam logic [7:0] B_UNDER   = 8'h5F;

    // Queue between the lexer front and the token back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    // Lexer modes, one-hot.
    typedef enum logic [7:0] {
        M_IDLE   = 8'b0000_0001,
        M_IDENT  = 8'b0000_0010,
        M_STRING = 8'b0000_0100,
        M_CHAR   = 8'b0000_1000,
        M_SLASH  = 8'b0001_0000,
        M_LINE   = 8'b0010_0000,
        M_BLOCK  = 8'b0100_0000,
        M_BSTAR  = 8'b1000_0000
    } t_mode;

    // One token as it leaves the block, offset and length already clamped.
    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] offset;
        logic [15:0] length;
    } t_token;

    // Everything one source byte produces: one or two tokens.
    typedef struct packed {
        logic   has_two;
        t_token first;
        t_token second;
    } t_step;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic is_alpha(logic [7:0] b);
        return b inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_ident(logic [7:0] b);
        return is_alpha(b) || (b inside {[8'h30:8'h39], B_UNDER});
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return b inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    // Kind of a byte that forms a token on its own.
    function automatic logic [4:0] single_kind(logic [7:0] b);
        logic [4:0] k;
        case (b)
            B_HASH:  k = K_HASH;
            8'h28:   k = K_LPAREN;
            8'h29:   k = K_RPAREN;
            8'h7B:   k = K_LBRACE;
            8'h7D:   k = K_RBRACE;
            8'h5B:   k = K_LBRACK;
            8'h5D:   k = K_RBRACK;
            8'h3B:   k = K_SEMI;
            8'h3A:   k = K_COLON;
            8'h3F:   k = K_QUEST;
            8'h2C:   k = K_COMMA;
            8'h25:   k = K_PERCENT;
            8'h3D:   k = K_ASSIGN;
            B_STAR:  k = K_STAR;
            8'h3C:   k = K_LESS;
            8'h3E:   k = K_GREATER;
            B_CARET: k = K_CARET;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/clx_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps
`default_nettype none

interface clx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface clx_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic        last_of_item;

    modport source (output valid, output token_kind, output token_offset,
                    output token_length, output last_of_item, input ready);
    modport sink   (input valid, input token_kind, input token_offset,
                    input token_length, input last_of_item, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/clx_front.sv =====
// Lexer front end: takes one source byte per cycle while the queue is not full and forms the tokens it closes.
`timescale 1ns / 1ps
`default_nettype none

module clx_front #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    clx_byte_if.sink                    i_in,
    input  wire clx_pkg::t_queue_status i_status,
    output logic                        o_push,
    output clx_pkg::t_step              o_step
);

    localparam int W = OFFSET_BITS;

    clx_pkg::t_mode r_mode, n_mode;
    logic [W-1:0]   r_start, n_start;
    logic [W-1:0]   r_run, n_run;
    logic [W-1:0]   r_pos, n_pos;

    logic           accept;
    logic [7:0]     b;
    logic [W-1:0]   run_inc;
    logic           open_v, fresh, fresh_v, end_hit;
    clx_pkg::t_token open_tok, fresh_tok;
    logic [4:0]     str_kind;
    logic [7:0]     str_quote;

    function automatic logic [W-1:0] sat_inc(logic [W-1:0] v);
        return (v != {W{1'b1}}) ? v + W'(1) : v;
    endfunction

    // Reported fields stop at 65535 whatever the counter width.
    function automatic logic [15:0] clamp(logic [W-1:0] v);
        logic [W+15:0] ext;
        ext = {16'b0, v};
        return (ext > (W+16)'(65535)) ? 16'hFFFF : ext[15:0];
    endfunction

    function automatic clx_pkg::t_token mk_tok(logic [4:0] kind, logic [W-1:0] off,
                                               logic [W-1:0] len);
        clx_pkg::t_token t;
        t.kind   = kind;
        t.offset = clamp(off);
        t.length = clamp(len);
        return t;
    endfunction

    assign i_in.ready = !i_status.full;
    assign accept     = i_in.valid && !i_status.full;
    assign b          = i_in.byte_in;
    assign run_inc    = sat_inc(r_run);
    assign str_kind   = (r_mode == clx_pkg::M_STRING) ? clx_pkg::K_STRING : clx_pkg::K_CHAR;
    assign str_quote  = (r_mode == clx_pkg::M_STRING) ? clx_pkg::B_DQUOTE : clx_pkg::B_SQUOTE;

    // Mode update: close the open token, then lex the byte afresh where needed.
    always_comb begin
        n_mode    = r_mode;
        n_start   = r_start;
        n_run     = r_run;
        n_pos     = r_pos;
        open_v    = 1'b0;
        open_tok  = '0;
        fresh     = 1'b0;
        fresh_v   = 1'b0;
        fresh_tok = '0;
        end_hit   = 1'b0;

        case (r_mode)
            clx_pkg::M_IDENT: begin
                if (b != clx_pkg::B_END && clx_pkg::is_ident(b)) begin
                    n_run = run_inc;
                end else begin
                    open_v   = 1'b1;
                    open_tok = mk_tok(clx_pkg::K_IDENT, r_start, r_run);
                    n_mode   = clx_pkg::M_IDLE;
                    fresh    = 1'b1;
                end
            end
            clx_pkg::M_STRING, clx_pkg::M_CHAR: begin
                if (b == clx_pkg::B_END) begin
                    open_v   = 1'b1;
                    open_tok = mk_tok(str_kind, r_start, r_run);
                    n_mode   = clx_pkg::M_IDLE;
                    fresh    = 1'b1;
                end else begin
                    n_run = run_inc;
                    if (b == str_quote) begin
                        open_v   = 1'b1;
                        open_tok = mk_tok(str_kind, r_start, run_inc);
                        n_mode   = clx_pkg::M_IDLE;
                    end
                end
            end
            clx_pkg::M_SLASH: begin
                if (b == clx_pkg::B_SLASH) begin
                    n_mode = clx_pkg::M_LINE;
                    n_run  = run_inc;
                end else if (b == clx_pkg::B_STAR) begin
                    n_mode = clx_pkg::M_BLOCK;
                    n_run  = run_inc;
                end else begin
                    open_v   = 1'b1;
                    open_tok = mk_tok(clx_pkg::K_DIVIDE, r_start, r_run);
                    n_mode   = clx_pkg::M_IDLE;
                    fresh    = 1'b1;
                end
            end
            clx_pkg::M_LINE: begin
                if (b == clx_pkg::B_END) begin
                    open_v   = 1'b1;
                    open_tok = mk_tok(clx_pkg::K_LINE, r_start, r_run);
                    n_mode   = clx_pkg::M_IDLE;
                    fresh    = 1'b1;
                end else begin
                    n_run = run_inc;
                    if (b == clx_pkg::B_NEWLINE) begin
                        open_v   = 1'b1;
                        open_tok = mk_tok(clx_pkg::K_LINE, r_start, run_inc);
                        n_mode   = clx_pkg::M_IDLE;
                    end
                end
            end
            clx_pkg::M_BLOCK, clx_pkg::M_BSTAR: begin
                if (b == clx_pkg::B_END) begin
                    open_v   = 1'b1;
                    open_tok = mk_tok(clx_pkg::K_BLOCK, r_start, r_run);
                    n_mode   = clx_pkg::M_IDLE;
                    fresh    = 1'b1;
                end else begin
                    n_run = run_inc;
                    if (r_mode == clx_pkg::M_BSTAR && b == clx_pkg::B_SLASH) begin
                        open_v   = 1'b1;
                        open_tok = mk_tok(clx_pkg::K_BLOCK, r_start, run_inc);
                        n_mode   = clx_pkg::M_IDLE;
                    end else begin
                        n_mode = (b == clx_pkg::B_STAR) ? clx_pkg::M_BSTAR : clx_pkg::M_BLOCK;
                    end
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase

        // Lex the byte from the idle mode.
        if (fresh) begin
            if (b == clx_pkg::B_END) begin
                fresh_v   = 1'b1;
                fresh_tok = mk_tok(clx_pkg::K_END, r_pos, '0);
                end_hit   = 1'b1;
                n_mode    = clx_pkg::M_IDLE;
                n_start   = '0;
                n_run     = '0;
            end else if (!clx_pkg::is_space(b)) begin
                n_start = r_pos;
                n_run   = W'(1);
                if (clx_pkg::is_alpha(b) || b == clx_pkg::B_UNDER) begin
                    n_mode = clx_pkg::M_IDENT;
                end else if (b == clx_pkg::B_DQUOTE) begin
                    n_mode = clx_pkg::M_STRING;
                end else if (b == clx_pkg::B_SQUOTE) begin
                    n_mode = clx_pkg::M_CHAR;
                end else if (b == clx_pkg::B_SLASH) begin
                    n_mode = clx_pkg::M_SLASH;
                end else begin
                    fresh_v   = 1'b1;
                    fresh_tok = mk_tok(clx_pkg::single_kind(b), r_pos, W'(1));
                end
            end
        end

        // The end marker restarts the stream at offset zero.
        n_pos = end_hit ? '0 : sat_inc(r_pos);
    end

    // Pack the tokens of this byte in emission order.
    always_comb begin
        if (open_v) begin
            o_step.has_two = fresh_v;
            o_step.first   = open_tok;
            o_step.second  = fresh_tok;
        end else begin
            o_step.has_two = 1'b0;
            o_step.first   = fresh_tok;
            o_step.second  = '0;
        end
    end

    assign o_push = accept && (open_v || fresh_v);

    // Lexer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= clx_pkg::M_IDLE;
            r_start <= '0;
            r_run   <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_run   <= n_run;
            r_pos   <= n_pos;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clx_queue.sv =====
// Short queue of per-byte token records between the lexer front and back.
`timescale 1ns / 1ps
`default_nettype none

module clx_queue (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire clx_pkg::t_step         i_step,
    input  wire logic                   i_pop,
    output clx_pkg::t_step              o_head,
    output clx_pkg::t_queue_status      o_status
);

    // Unit steps at the pointer and count widths.
    localparam logic [clx_pkg::QPTR_BITS-1:0] PTR_ONE =
        {{(clx_pkg::QPTR_BITS-1){1'b0}}, 1'b1};
    localparam logic [clx_pkg::QPTR_BITS:0]   CNT_ONE =
        {{clx_pkg::QPTR_BITS{1'b0}}, 1'b1};

    clx_pkg::t_step                 r_mem [clx_pkg::QUEUE_DEPTH];
    logic [clx_pkg::QPTR_BITS-1:0]  r_wr_ptr;
    logic [clx_pkg::QPTR_BITS-1:0]  r_rd_ptr;
    logic [clx_pkg::QPTR_BITS:0]    r_count;
    logic                           do_pop;

    assign o_status.full  = (r_count == (clx_pkg::QPTR_BITS+1)'(clx_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];
    assign do_pop         = i_pop && !o_status.empty;

    // Record storage; the front never pushes when full.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_step;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_ONE;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_ONE;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CNT_ONE;
                2'b01:   r_count <= r_count - CNT_ONE;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/clx_back.sv =====
// Token back end: sends the one or two tokens of each queued record as separate words.
`timescale 1ns / 1ps
`default_nettype none

module clx_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire clx_pkg::t_step         i_head,
    input  wire clx_pkg::t_queue_status i_status,
    output logic                        o_pop,
    clx_token_if.source                 o_out
);

    // Set while the second token of the head record is on the port.
    logic            r_phase;
    logic            take;
    clx_pkg::t_token cur;

    assign cur                = r_phase ? i_head.second : i_head.first;
    assign o_out.valid        = !i_status.empty;
    assign o_out.token_kind   = cur.kind;
    assign o_out.token_offset = cur.offset;
    assign o_out.token_length = cur.length;
    assign o_out.last_of_item = !i_head.has_two || r_phase;

    assign take  = o_out.valid && o_out.ready;
    assign o_pop = take && (!i_head.has_two || r_phase);

    // Step through the tokens of the head record.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (take) begin
            r_phase <= i_head.has_two && !r_phase;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/c_token_lexer_unit.sv =====
// Top level of the C token lexer: byte front end, record queue and token back end.
// Path: a token closed by a byte is written to the queue when the byte is taken, then sent from the queue head.
// Throughput: one byte per cycle while the queue is not full; a byte that yields two tokens
// is sent as two output words, and the four-record queue absorbs those while the front keeps taking bytes.
// Reset: synchronous, active low; clears the lexer mode, counters and queue pointers.
// The end-of-stream byte returns the lexer to its reset state by itself.
`timescale 1ns / 1ps
`default_nettype none

module c_token_lexer_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clx_byte_if.sink    i_in,
    clx_token_if.source o_out
);

    clx_pkg::t_step         w_push_step;
    clx_pkg::t_step         w_head;
    clx_pkg::t_queue_status w_status;
    logic                   w_push;
    logic                   w_pop;

    // Byte classification and token forming.
    clx_front #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_status (w_status),
        .o_push   (w_push),
        .o_step   (w_push_step)
    );

    // Decoupling queue.
    clx_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_step   (w_push_step),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_status)
    );

    // Token output.
    clx_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_status (w_status),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire
